@@ hdl/adcmaf_pkg.sv @@
// shared types, constants and state codes for the adc moving-average fir block
// no dependencies

package adcmaf_pkg;

  localparam int TAP_COUNT_DEF = 16;

  localparam int                 SAMPLE_W     = 12;
  localparam int                 Q15_W        = 16;
  localparam int                 FRAC_BITS    = 15;
  localparam int                 CENTRE_SHIFT = 4;
  localparam logic signed [12:0] ADC_MID      = 13'sd2048;
  localparam logic signed [15:0] Q15_MAX      = 16'sh7FFF;
  localparam logic signed [15:0] Q15_MIN      = 16'sh8000;

  localparam logic signed [15:0] GAIN_RESET   = 16'sd2048;
  localparam logic [15:0]        SETTLE_RESET = 16'd16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_GAIN = 1'd0,
    CFG_SETTLE   = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_MUL,
    ST_SCALE,
    ST_SQUARE,
    ST_COMMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [11:0] adc_sample;
    logic        clear_stats;
  } in_t;

  typedef struct packed {
    logic signed [15:0] filtered_sample;
    logic signed [15:0] centred_sample;
    logic [31:0]        sample_total;
    logic [31:0]        valid_total;
    logic signed [47:0] raw_sum;
    logic signed [47:0] filtered_sum;
    logic [61:0]        raw_square_sum;
    logic [61:0]        filtered_square_sum;
    logic signed [15:0] raw_minimum;
    logic signed [15:0] raw_maximum;
    logic signed [15:0] filtered_minimum;
    logic signed [15:0] filtered_maximum;
  } out_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic square;
    logic commit;
  } stat_ctl_t;

  typedef struct packed {
    logic [31:0]        sample_total;
    logic [31:0]        valid_total;
    logic signed [47:0] raw_sum;
    logic signed [47:0] filtered_sum;
    logic [61:0]        raw_square_sum;
    logic [61:0]        filtered_square_sum;
    logic signed [15:0] raw_minimum;
    logic signed [15:0] raw_maximum;
    logic signed [15:0] filtered_minimum;
    logic signed [15:0] filtered_maximum;
  } stats_t;

endpackage

@@ hdl/adc_moving_average_fir_stats_core.sv @@
// The delay-line memory is read once per tap while the shared-gain sum is built
// for each item. The 12-bit reading is centred to Q15, written over the oldest
// tap, the taps are summed, multiplied by tap_gain, shifted right by 15 and
// clipped, and the statistics are then updated. One item is in work at a time;
// the next item is taken while the previous result still waits in the output
// register. Configuration writes take effect at once and belong to idle periods
// only.
// depends on adcmaf_pkg, adcmaf_tap_mem, adcmaf_stats

module adc_moving_average_fir_stats_core #(
  parameter int TAP_COUNT = adcmaf_pkg::TAP_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  adcmaf_pkg::in_t                      in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output adcmaf_pkg::out_t                     out_data,
  input  logic                                 cfg_we,
  input  logic [adcmaf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adcmaf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int               IDX_W  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int               SUM_W  = adcmaf_pkg::Q15_W + $clog2(TAP_COUNT);
  localparam int               PROD_W = SUM_W + adcmaf_pkg::Q15_W;
  localparam logic [IDX_W-1:0] LAST   = IDX_W'(TAP_COUNT - 1);

  adcmaf_pkg::state_t  state_r, state_nxt;
  logic [IDX_W-1:0]    cnt_r;
  logic [IDX_W-1:0]    wp_r;
  logic                acc_en_r;
  logic                out_valid_r;
  adcmaf_pkg::out_t    out_data_r;
  logic signed [15:0]  tap_gain_r;
  logic [15:0]         settle_r;

  logic signed [15:0]       raw_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [15:0]       filt_r;

  logic                    accept;
  logic                    out_load;
  logic                    sweep;
  adcmaf_pkg::stat_ctl_t   ctl;
  adcmaf_pkg::stats_t      stats;

  logic signed [12:0]       centred_w;
  logic signed [15:0]       raw_in;
  logic signed [15:0]       rd_data;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] shifted;
  logic signed [15:0]       filt_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      adcmaf_pkg::ST_IDLE:   if (in_valid) state_nxt = adcmaf_pkg::ST_SWEEP;
      adcmaf_pkg::ST_SWEEP:  if (cnt_r == LAST) state_nxt = adcmaf_pkg::ST_DRAIN;
      adcmaf_pkg::ST_DRAIN:  state_nxt = adcmaf_pkg::ST_MUL;
      adcmaf_pkg::ST_MUL:    state_nxt = adcmaf_pkg::ST_SCALE;
      adcmaf_pkg::ST_SCALE:  state_nxt = adcmaf_pkg::ST_SQUARE;
      adcmaf_pkg::ST_SQUARE: state_nxt = adcmaf_pkg::ST_COMMIT;
      adcmaf_pkg::ST_COMMIT: state_nxt = adcmaf_pkg::ST_DONE;
      adcmaf_pkg::ST_DONE:   if (!out_valid_r || out_ready) state_nxt = adcmaf_pkg::ST_IDLE;
      default:               state_nxt = adcmaf_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    sweep      = 1'b0;
    out_load   = 1'b0;
    ctl.square = 1'b0;
    ctl.commit = 1'b0;
    case (state_r)
      adcmaf_pkg::ST_IDLE:   in_ready = 1'b1;
      adcmaf_pkg::ST_SWEEP:  sweep = 1'b1;
      adcmaf_pkg::ST_SQUARE: ctl.square = 1'b1;
      adcmaf_pkg::ST_COMMIT: ctl.commit = 1'b1;
      adcmaf_pkg::ST_DONE:   out_load = !out_valid_r || out_ready;
      default:               in_ready = 1'b0;
    endcase
    accept    = in_ready && in_valid;
    ctl.start = accept;
    ctl.clear = in_data.clear_stats;
  end

  // centre to q15, scale and clip
  always_comb begin
    centred_w = $signed({1'b0, in_data.adc_sample}) - adcmaf_pkg::ADC_MID;
    raw_in    = 16'(centred_w) <<< adcmaf_pkg::CENTRE_SHIFT;
    prod_nxt  = tap_gain_r * sum_r;
    shifted   = prod_r >>> adcmaf_pkg::FRAC_BITS;
    if (shifted > PROD_W'(adcmaf_pkg::Q15_MAX)) begin
      filt_nxt = adcmaf_pkg::Q15_MAX;
    end else if (shifted < PROD_W'(adcmaf_pkg::Q15_MIN)) begin
      filt_nxt = adcmaf_pkg::Q15_MIN;
    end else begin
      filt_nxt = shifted[15:0];
    end
  end

  adcmaf_tap_mem #(
    .TAP_COUNT (TAP_COUNT)
  ) u_tap_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_addr (wp_r),
    .wr_data (raw_in),
    .rd_addr (cnt_r),
    .rd_data (rd_data)
  );

  adcmaf_stats u_stats (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .raw    (raw_r),
    .filt   (filt_r),
    .settle (settle_r),
    .stats  (stats)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= adcmaf_pkg::ST_IDLE;
      cnt_r       <= '0;
      wp_r        <= '0;
      acc_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
      tap_gain_r  <= adcmaf_pkg::GAIN_RESET;
      settle_r    <= adcmaf_pkg::SETTLE_RESET;
    end else begin
      state_r  <= state_nxt;
      acc_en_r <= sweep;
      cnt_r    <= (sweep && cnt_r != LAST) ? cnt_r + 1'b1 : '0;
      if (accept) begin
        wp_r <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          adcmaf_pkg::CFG_TAP_GAIN: tap_gain_r <= cfg_data;
          adcmaf_pkg::CFG_SETTLE:   settle_r   <= cfg_data;
          default:                  settle_r   <= settle_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_r <= raw_in;
      sum_r <= '0;
    end else if (acc_en_r) begin
      sum_r <= sum_r + SUM_W'(rd_data);
    end
    if (state_r == adcmaf_pkg::ST_MUL) begin
      prod_r <= prod_nxt;
    end
    if (state_r == adcmaf_pkg::ST_SCALE) begin
      filt_r <= filt_nxt;
    end
    if (out_load) begin
      out_data_r.filtered_sample     <= filt_r;
      out_data_r.centred_sample      <= raw_r;
      out_data_r.sample_total        <= stats.sample_total;
      out_data_r.valid_total         <= stats.valid_total;
      out_data_r.raw_sum             <= stats.raw_sum;
      out_data_r.filtered_sum        <= stats.filtered_sum;
      out_data_r.raw_square_sum      <= stats.raw_square_sum;
      out_data_r.filtered_square_sum <= stats.filtered_square_sum;
      out_data_r.raw_minimum         <= stats.raw_minimum;
      out_data_r.raw_maximum         <= stats.raw_maximum;
      out_data_r.filtered_minimum    <= stats.filtered_minimum;
      out_data_r.filtered_maximum    <= stats.filtered_maximum;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == adcmaf_pkg::ST_SWEEP)
    else $error("accepted item did not start the tap sweep");

  a_sweep_covers_taps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == adcmaf_pkg::ST_DRAIN) |-> $past(cnt_r) == LAST && $past(acc_en_r || TAP_COUNT == 1))
    else $error("tap sweep ended before reading every tap");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == adcmaf_pkg::ST_DONE && !out_valid_r) |=> out_valid_r && state_r == adcmaf_pkg::ST_IDLE)
    else $error("finished item not moved to the output register");

  a_write_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= LAST)
    else $error("write pointer outside the delay line");

endmodule

@@ hdl/adcmaf_tap_mem.sv @@
// delay line storage: circular sample memory, one write and one registered read
// per cycle, with a valid bit per entry so unwritten taps read as zero
// depends on adcmaf_pkg

module adcmaf_tap_mem #(
  parameter  int TAP_COUNT = adcmaf_pkg::TAP_COUNT_DEF,
  localparam int IDX_W     = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [IDX_W-1:0]              wr_addr,
  input  logic signed [adcmaf_pkg::Q15_W-1:0] wr_data,
  input  logic [IDX_W-1:0]              rd_addr,
  output logic signed [adcmaf_pkg::Q15_W-1:0] rd_data
);

  logic signed [adcmaf_pkg::Q15_W-1:0] mem_r [TAP_COUNT];
  logic signed [adcmaf_pkg::Q15_W-1:0] rd_q_r;
  logic [TAP_COUNT-1:0]                vld_r;
  logic                                rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_q_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

@@ hdl/adcmaf_stats.sv @@
// running statistics: sample counters, sums, sums of squares and extrema of the
// centred and filtered values, with clear and settle handling
// depends on adcmaf_pkg

module adcmaf_stats (
  input  logic                      clk,
  input  logic                      rst_n,
  input  adcmaf_pkg::stat_ctl_t     ctl,
  input  logic signed [15:0]        raw,
  input  logic signed [15:0]        filt,
  input  logic [15:0]               settle,
  output adcmaf_pkg::stats_t        stats
);

  logic [31:0]        seen_r;
  logic [31:0]        counted_r;
  logic [47:0]        raw_acc_r;
  logic [47:0]        filt_acc_r;
  logic [61:0]        raw_sq_acc_r;
  logic [61:0]        filt_sq_acc_r;
  logic signed [15:0] raw_lo_r;
  logic signed [15:0] raw_hi_r;
  logic signed [15:0] filt_lo_r;
  logic signed [15:0] filt_hi_r;
  logic               count_en_r;
  logic [31:0]        raw_sq_r;
  logic [31:0]        filt_sq_r;

  logic [31:0]        seen_nxt;
  logic signed [31:0] raw_sq_nxt;
  logic signed [31:0] filt_sq_nxt;

  always_comb begin
    seen_nxt    = (ctl.clear ? 32'd0 : seen_r) + 32'd1;
    raw_sq_nxt  = raw * raw;
    filt_sq_nxt = filt * filt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r        <= '0;
      counted_r     <= '0;
      raw_acc_r     <= '0;
      filt_acc_r    <= '0;
      raw_sq_acc_r  <= '0;
      filt_sq_acc_r <= '0;
      raw_lo_r      <= adcmaf_pkg::Q15_MAX;
      raw_hi_r      <= adcmaf_pkg::Q15_MIN;
      filt_lo_r     <= adcmaf_pkg::Q15_MAX;
      filt_hi_r     <= adcmaf_pkg::Q15_MIN;
      count_en_r    <= 1'b0;
      raw_sq_r      <= '0;
      filt_sq_r     <= '0;
    end else begin
      if (ctl.start) begin
        if (ctl.clear) begin
          counted_r     <= '0;
          raw_acc_r     <= '0;
          filt_acc_r    <= '0;
          raw_sq_acc_r  <= '0;
          filt_sq_acc_r <= '0;
          raw_lo_r      <= adcmaf_pkg::Q15_MAX;
          raw_hi_r      <= adcmaf_pkg::Q15_MIN;
          filt_lo_r     <= adcmaf_pkg::Q15_MAX;
          filt_hi_r     <= adcmaf_pkg::Q15_MIN;
        end
        seen_r     <= seen_nxt;
        count_en_r <= seen_nxt > {16'd0, settle};
      end
      if (ctl.square) begin
        raw_sq_r  <= raw_sq_nxt;
        filt_sq_r <= filt_sq_nxt;
      end
      if (ctl.commit && count_en_r) begin
        counted_r     <= counted_r + 32'd1;
        raw_acc_r     <= raw_acc_r + 48'(raw);
        filt_acc_r    <= filt_acc_r + 48'(filt);
        raw_sq_acc_r  <= raw_sq_acc_r + 62'(raw_sq_r);
        filt_sq_acc_r <= filt_sq_acc_r + 62'(filt_sq_r);
        if (raw < raw_lo_r) raw_lo_r <= raw;
        if (raw > raw_hi_r) raw_hi_r <= raw;
        if (filt < filt_lo_r) filt_lo_r <= filt;
        if (filt > filt_hi_r) filt_hi_r <= filt;
      end
    end
  end

  always_comb begin
    stats.sample_total        = seen_r;
    stats.valid_total         = counted_r;
    stats.raw_sum             = raw_acc_r;
    stats.filtered_sum        = filt_acc_r;
    stats.raw_square_sum      = raw_sq_acc_r;
    stats.filtered_square_sum = filt_sq_acc_r;
    stats.raw_minimum         = raw_lo_r;
    stats.raw_maximum         = raw_hi_r;
    stats.filtered_minimum    = filt_lo_r;
    stats.filtered_maximum    = filt_hi_r;
  end

endmodule
